@@ design/ptts_pkg.sv @@
// ----------------------------------------------------------------------------
// ptts_pkg: shared types and constants of the periodic task tick scheduler.
// Holds slot counts, field widths, command codes and the controller bundles.
// ----------------------------------------------------------------------------
package ptts_pkg;

    localparam int NUM_TASKS = 8;
    localparam int SLOT_W    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CMD_W     = 3;
    localparam int ID_W      = 3;
    localparam int TIME_W    = 16;
    localparam int MASK_W    = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 3'd0,
        CMD_CREATE  = 3'd1,
        CMD_SUSPEND = 3'd2,
        CMD_RESUME  = 3'd3,
        CMD_DELETE  = 3'd4
    } command_t;

    typedef struct packed {
        logic apply_cmd;
        logic tick_start;
        logic tick_step;
        logic load_result;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_slot;
    } dp_status_t;

endpackage

@@ design/ptts_if.sv @@
// ----------------------------------------------------------------------------
// ptts_if: handshake channels of the periodic task tick scheduler.
// One interface carries requests, the other carries fired masks.
// ----------------------------------------------------------------------------
interface ptts_req_if
    import ptts_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] first_delay;

    modport source (output valid, command, task_id, period, first_delay, input ready);
    modport sink (input valid, command, task_id, period, first_delay, output ready);
endinterface

interface ptts_res_if
    import ptts_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] fired_mask;

    modport source (output valid, fired_mask, input ready);
    modport sink (input valid, fired_mask, output ready);
endinterface

@@ design/ptts_datapath.sv @@
// ----------------------------------------------------------------------------
// ptts_datapath: task slot storage, slot walk counter and fired mask register.
// Applies slot commands and visits one slot per cycle during a tick.
// ----------------------------------------------------------------------------
module ptts_datapath
    import ptts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    input  logic [CMD_W-1:0]  command,
    input  logic [ID_W-1:0]   task_id,
    input  logic [TIME_W-1:0] period,
    input  logic [TIME_W-1:0] first_delay,
    output dp_status_t        status,
    output logic [MASK_W-1:0] fired_mask
);

    logic [TIME_W-1:0] period_reg    [NUM_TASKS];
    logic [TIME_W-1:0] countdown_reg [NUM_TASKS];
    logic [NUM_TASKS-1:0] present_reg, present_next;
    logic [NUM_TASKS-1:0] ready_reg, ready_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [MASK_W-1:0] acc_reg, acc_next;
    logic [MASK_W-1:0] mask_reg, mask_next;

    logic              id_valid;
    logic [SLOT_W-1:0] id_slot;
    logic              slot_active;
    logic              slot_zero;
    logic [TIME_W-1:0] cd_cur;
    logic [TIME_W-1:0] cd_new;

    assign id_valid    = (32'(task_id) < NUM_TASKS);
    assign id_slot     = SLOT_W'(task_id);
    assign cd_cur      = countdown_reg[slot_reg];
    assign slot_active = present_reg[slot_reg] && ready_reg[slot_reg];
    assign slot_zero   = (cd_cur == '0);
    assign cd_new      = slot_zero ? (period_reg[slot_reg] - TIME_W'(1)) : (cd_cur - TIME_W'(1));

    always_comb
    begin
        present_next = present_reg;
        ready_next   = ready_reg;
        if (cmd.apply_cmd && id_valid)
        begin
            case (command)
                CMD_CREATE:
                begin
                    present_next[id_slot] = 1'b1;
                    ready_next[id_slot]   = 1'b1;
                end
                CMD_SUSPEND: ready_next[id_slot] = 1'b0;
                CMD_RESUME:  ready_next[id_slot] = 1'b1;
                CMD_DELETE:  present_next[id_slot] = 1'b0;
                default:
                begin
                    present_next = present_reg;
                    ready_next   = ready_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        slot_next = slot_reg;
        acc_next  = acc_reg;
        if (cmd.tick_start)
        begin
            slot_next = '0;
            acc_next  = '0;
        end
        else if (cmd.tick_step)
        begin
            slot_next = slot_reg + SLOT_W'(1);
            if (slot_active && slot_zero)
            begin
                acc_next = acc_reg | (MASK_W'(1) << slot_reg);
            end
        end
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (cmd.apply_cmd)
        begin
            mask_next = '0;
        end
        else if (cmd.load_result)
        begin
            mask_next = acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            ready_reg   <= '0;
            slot_reg    <= '0;
            acc_reg     <= '0;
            mask_reg    <= '0;
        end
        else
        begin
            present_reg <= present_next;
            ready_reg   <= ready_next;
            slot_reg    <= slot_next;
            acc_reg     <= acc_next;
            mask_reg    <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply_cmd && id_valid && (command == CMD_CREATE))
        begin
            period_reg[id_slot]    <= period;
            countdown_reg[id_slot] <= first_delay;
        end
        else if (cmd.tick_step && slot_active)
        begin
            countdown_reg[slot_reg] <= cd_new;
        end
    end

    assign status.last_slot = (32'(slot_reg) == (NUM_TASKS - 1));
    assign fired_mask       = mask_reg;

endmodule

@@ design/ptts_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptts_ctrl: request and result control of the periodic task tick scheduler.
// Accepts requests, sequences the slot walk of a tick and owns result valid.
// ----------------------------------------------------------------------------
module ptts_ctrl
    import ptts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [CMD_W-1:0] command,
    output logic             req_ready,
    input  logic             res_ready,
    output logic             res_valid,
    input  dp_status_t       status,
    output ctrl_cmd_t        cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign req_ready = (state_reg == ST_IDLE) && (!out_valid_reg || res_ready);
    assign accept    = req_ready && req_valid;

    always_comb
    begin
        cmd.apply_cmd   = accept && (command != CMD_TICK);
        cmd.tick_start  = accept && (command == CMD_TICK);
        cmd.tick_step   = (state_reg == ST_WALK);
        cmd.load_result = (state_reg == ST_WALK) && status.last_slot;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.tick_start)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (status.last_slot)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.apply_cmd || cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign res_valid = out_valid_reg;

endmodule

@@ design/periodic_task_tick_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_top: bank of per-slot periodic countdown timers.
// Create, suspend, resume, delete and the spare codes give their empty result
// in the next cycle. A tick walks one slot per cycle and then loads its mask.
// A tick blocks the request channel until its walk ends; other commands
// can be taken every cycle while the result side keeps up.
// Reset clears all present and ready flags and empties the result register.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_top
    import ptts_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    ptts_req_if.sink request,
    ptts_res_if.source result
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    ptts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .command   (request.command),
        .req_ready (request.ready),
        .res_ready (result.ready),
        .res_valid (result.valid),
        .status    (status),
        .cmd       (cmd)
    );

    ptts_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .command     (request.command),
        .task_id     (request.task_id),
        .period      (request.period),
        .first_delay (request.first_delay),
        .status      (status),
        .fired_mask  (result.fired_mask)
    );

    // A transaction is only taken when the result register is free or draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |-> (!result.valid || result.ready))
        else $error("request accepted while result register is blocked");

    assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready && (request.command != CMD_TICK))
        |=> (result.valid && (result.fired_mask == '0)))
        else $error("slot command did not return an empty mask");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !request.ready)
        else $error("request ready while result is stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick_step |-> !request.ready)
        else $error("request ready during a slot walk");

endmodule

@@ sim/ptts_fired_mask_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_fired_mask_checker: scoreboard for the periodic task tick scheduler.
// Watches both channels. For every request transaction it runs its own model
// of the slot timers and queues the fired mask that the request must produce.
// Each result transaction is then compared with the oldest queued mask.
// ----------------------------------------------------------------------------
module ptts_fired_mask_checker
    import ptts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ptts_req_if  request,
    ptts_res_if  result,
    output int   fail_count,
    output int   outstanding,
    output int   masks_checked,
    output int   fire_events
);

    localparam int MAX_PRINTED = 20;

    logic [TIME_W-1:0] slot_period    [NUM_TASKS];
    logic [TIME_W-1:0] slot_countdown [NUM_TASKS];
    logic              slot_ready     [NUM_TASKS];
    logic              slot_present   [NUM_TASKS];
    logic [MASK_W-1:0] expected_masks [$];

    task automatic report_mismatch(input string detail);
        fail_count++;
        if (fail_count <= MAX_PRINTED)
        begin
            $display("[%0t] MISMATCH: %s", $time, detail);
        end
    endtask

    function automatic logic [MASK_W-1:0] advance_schedule(
        input logic [CMD_W-1:0]  command,
        input logic [ID_W-1:0]   slot_id,
        input logic [TIME_W-1:0] period,
        input logic [TIME_W-1:0] first_delay
    );
        logic [MASK_W-1:0] fired;
        int                slot;
        fired = '0;
        slot  = int'(slot_id);
        if (command == CMD_TICK)
        begin
            for (int s = 0; s < NUM_TASKS; s++)
            begin
                if (slot_present[s] && slot_ready[s])
                begin
                    if (slot_countdown[s] == '0)
                    begin
                        slot_countdown[s] = slot_period[s] - 1'b1;
                        if (s < MASK_W)
                        begin
                            fired[s] = 1'b1;
                        end
                    end
                    else
                    begin
                        slot_countdown[s] = slot_countdown[s] - 1'b1;
                    end
                end
            end
        end
        else if (slot < NUM_TASKS)
        begin
            case (command)
                CMD_CREATE:
                begin
                    slot_period[slot]    = period;
                    slot_countdown[slot] = first_delay;
                    slot_present[slot]   = 1'b1;
                    slot_ready[slot]     = 1'b1;
                end
                CMD_SUSPEND: slot_ready[slot] = 1'b0;
                CMD_RESUME:  slot_ready[slot] = 1'b1;
                CMD_DELETE:  slot_present[slot] = 1'b0;
                default:     ;
            endcase
        end
        return fired;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [MASK_W-1:0] wanted;
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_TASKS; s++)
            begin
                slot_period[s]    = '0;
                slot_countdown[s] = '0;
                slot_ready[s]     = 1'b0;
                slot_present[s]   = 1'b0;
            end
            expected_masks.delete();
            outstanding = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_masks.size() == 0)
                begin
                    report_mismatch($sformatf("fired_mask %02h with no request pending",
                                              result.fired_mask));
                end
                else
                begin
                    wanted = expected_masks.pop_front();
                    masks_checked++;
                    fire_events += $countones(result.fired_mask);
                    if (result.fired_mask !== wanted)
                    begin
                        report_mismatch($sformatf("fired_mask %02h, expected %02h",
                                                  result.fired_mask, wanted));
                    end
                end
            end
            if (request.valid && request.ready)
            begin
                expected_masks.push_back(advance_schedule(request.command, request.task_id,
                                                          request.period,
                                                          request.first_delay));
            end
            outstanding = expected_masks.size();
        end
    end

endmodule

@@ sim/periodic_task_tick_scheduler_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_top_tb: testbench of the tick scheduler.
// Drives a directed sequence of slot commands and ticks, then a long random
// mix with short periods so that slots fire often, with random gaps on the
// request side and random stalls on the result side. A separate checker
// predicts every fired mask and counts mismatches; this module gives the verdict.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_top_tb;
    import ptts_pkg::*;

    localparam int                CLK_PERIOD      = 8;
    localparam int                RESET_CYCLES    = 9;
    localparam int                RANDOM_ITEMS    = 1625;
    localparam int                CALM_ITEMS      = 250;
    localparam int                DRAIN_CYCLES    = 4 * NUM_TASKS;
    localparam int                CYCLE_LIMIT     = 400000;
    localparam logic [CMD_W-1:0]  CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0]  CMD_SPARE_LAST  = 3'd7;

    logic clk;
    logic rst_n;
    logic idle_enabled;
    int   stall_left;
    int   cycle_count;
    int   sent_count;
    int   tick_count;
    int   fail_count;
    int   outstanding;
    int   masks_checked;
    int   fire_events;

    ptts_req_if req_ch ();
    ptts_res_if res_ch ();

    periodic_task_tick_scheduler_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch.sink),
        .result  (res_ch.source)
    );

    ptts_fired_mask_checker scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .request       (req_ch),
        .result        (res_ch),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .masks_checked (masks_checked),
        .fire_events   (fire_events)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d masks outstanding",
                     cycle_count, outstanding);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end
        else if (idle_enabled && $urandom_range(99) < 15)
        begin
            stall_left   <= $urandom_range(8, 0);
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
        end
    end

    function automatic logic [TIME_W-1:0] pick_ticks();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return TIME_W'($urandom);
            4:       return TIME_W'($urandom_range(40, 9));
            default: return TIME_W'($urandom_range(8));
        endcase
    endfunction

    task automatic send_request(
        input logic [CMD_W-1:0]  command,
        input logic [ID_W-1:0]   slot_id,
        input logic [TIME_W-1:0] period,
        input logic [TIME_W-1:0] first_delay
    );
        int gap;
        if (idle_enabled && $urandom_range(99) < 20)
        begin
            gap = $urandom_range(9, 1);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.command     <= command;
        req_ch.task_id     <= slot_id;
        req_ch.period      <= period;
        req_ch.first_delay <= first_delay;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sent_count++;
        if (command == CMD_TICK)
        begin
            tick_count++;
        end
    endtask

    initial
    begin
        int                r;
        logic [CMD_W-1:0]  command;
        rst_n              <= 1'b0;
        idle_enabled       <= 1'b1;
        req_ch.valid       <= 1'b0;
        req_ch.command     <= CMD_TICK;
        req_ch.task_id     <= '0;
        req_ch.period      <= '0;
        req_ch.first_delay <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(CMD_TICK, 3'd0, 16'hFFFF, 16'hFFFF);
        send_request(CMD_CREATE, 3'd0, 16'd1, 16'd0);
        send_request(CMD_CREATE, 3'd1, 16'd0, 16'd0);
        send_request(CMD_CREATE, 3'd7, 16'hFFFF, 16'hFFFF);
        send_request(CMD_CREATE, 3'd2, 16'd3, 16'd1);
        send_request(CMD_CREATE, 3'd3, 16'd2, 16'd0);
        send_request(CMD_TICK, 3'd0, 16'd0, 16'd0);
        send_request(CMD_TICK, 3'd0, 16'd0, 16'd0);
        send_request(CMD_TICK, 3'd0, 16'd0, 16'd0);
        send_request(CMD_SUSPEND, 3'd2, 16'd0, 16'd0);
        send_request(CMD_TICK, 3'd0, 16'd0, 16'd0);
        send_request(CMD_RESUME, 3'd2, 16'd0, 16'd0);
        send_request(CMD_SUSPEND, 3'd5, 16'd0, 16'd0);
        send_request(CMD_RESUME, 3'd6, 16'd0, 16'd0);
        send_request(CMD_DELETE, 3'd3, 16'd0, 16'd0);
        send_request(CMD_TICK, 3'd0, 16'd0, 16'd0);
        send_request(CMD_RESUME, 3'd3, 16'd0, 16'd0);
        send_request(CMD_TICK, 3'd0, 16'd0, 16'd0);
        send_request(CMD_SPARE_FIRST, 3'd4, 16'h1234, 16'h0000);
        send_request(CMD_SPARE_FIRST + 3'd1, 3'd0, 16'h0000, 16'h0000);
        send_request(CMD_SPARE_LAST, 3'd7, 16'hFFFF, 16'hFFFF);
        send_request(CMD_CREATE, 3'd4, 16'hAAAA, 16'h5555);
        send_request(CMD_CREATE, 3'd5, 16'h5555, 16'hAAAA);
        send_request(CMD_CREATE, 3'd3, 16'd2, 16'd1);
        send_request(CMD_TICK, 3'd0, 16'd0, 16'd0);

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            idle_enabled <= !(k >= 600 && k < 700) && (k < RANDOM_ITEMS - CALM_ITEMS);
            r = $urandom_range(99);
            if (r < 45)
            begin
                command = CMD_TICK;
            end
            else if (r < 63)
            begin
                command = CMD_CREATE;
            end
            else if (r < 73)
            begin
                command = CMD_SUSPEND;
            end
            else if (r < 83)
            begin
                command = CMD_RESUME;
            end
            else if (r < 93)
            begin
                command = CMD_DELETE;
            end
            else
            begin
                command = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
            end
            if (command == CMD_CREATE)
            begin
                send_request(command, ID_W'($urandom_range(7)), pick_ticks(), pick_ticks());
            end
            else
            begin
                send_request(command, ID_W'($urandom_range(7)), TIME_W'($urandom),
                             TIME_W'($urandom));
            end
        end
        req_ch.valid <= 1'b0;

        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests, %0d of them ticks, in %0d cycles.",
                 sent_count, tick_count, cycle_count);
        $display("Compared %0d fired masks carrying %0d slot firings; %0d mismatches.",
                 masks_checked, fire_events, fail_count);
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
